FILE: sv/delta_list_timer_queue_assert.svh
// Assertion macros shared by the timer queue RTL.
`ifndef DELTA_LIST_TIMER_QUEUE_ASSERT_SVH
`define DELTA_LIST_TIMER_QUEUE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DLTQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer queue assertion failed");

// Implication whose consequent is checked in the next cycle.
`define DLTQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer queue assertion failed");

`endif

FILE: sv/dltq_pkg.sv
package dltq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  // At most this many expiries are reported for one tick.
  localparam int MAX_RES       = 16;
  localparam int POP_W         = $clog2(MAX_RES + 1);
  localparam int ID_W          = 32;
  localparam int DELAY_W       = 32;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_CANCEL = 2'd1,
    FUNC_TICK   = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    KIND_EXPIRED   = 3'd0,
    KIND_INSERTED  = 3'd1,
    KIND_REJECTED  = 3'd2,
    KIND_CANCELLED = 3'd3,
    KIND_NOT_FOUND = 3'd4
  } kind_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [DELAY_W-1:0] delta;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_SCAN,
    ST_INS_SHIFT,
    ST_INS_TAIL,
    ST_CAN_SCAN,
    ST_CAN_SHIFT,
    ST_TICK_HEAD,
    ST_TICK_NEXT,
    ST_RESP
  } state_t;

endpackage

FILE: sv/dltq_cmd_if.sv
interface dltq_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] timer_id;
  logic [31:0] delay_ticks;

  modport source (output valid, func, timer_id, delay_ticks, input ready);
  modport sink   (input valid, func, timer_id, delay_ticks, output ready);
endinterface

FILE: sv/dltq_res_if.sv
interface dltq_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] timer_id_res;
  logic        last;

  modport source (output valid, kind, timer_id_res, last, input ready);
  modport sink   (input valid, kind, timer_id_res, last, output ready);
endinterface

FILE: sv/dltq_ram.sv
module dltq_ram #(
  parameter int WIDTH = dltq_pkg::ENTRY_W,
  parameter int DEPTH = dltq_pkg::DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data holds its value while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/delta_list_timer_queue.sv
// Delta-list timer queue.
// Commands arrive as words on the cmd channel (valid/ready): insert a timer
// with an id and a delay in ticks, cancel a timer by id, or advance time by
// one tick. Results leave as words on the res channel: one word for each
// insert or cancel, and one word per expired timer for a tick (none if the
// queue is empty or nothing expires); last marks the final word of a command.
// Pending timers live in one entry memory of DEPTH words, a ring starting at
// the head pointer, each word holding an id and a delay relative to the
// entry before it.
// A command is taken only while the controller is idle. An insert walks the
// ring one entry per cycle, reading it through the single read port of the
// entry memory.
// Reset empties the queue at once; the memory needs no clearing pass.
// A result sits in an output register, so the next command is accepted while
// it waits; if the receiver stalls further words, the controller holds.
module delta_list_timer_queue #(
  parameter int DEPTH = dltq_pkg::DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  dltq_cmd_if.sink   cmd,
  dltq_res_if.source res
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int NW = dltq_pkg::POP_W;

  dltq_pkg::state_t state, state_next;

  logic [CW-1:0] count, count_next;
  logic [AW-1:0] head, head_next;
  logic [AW-1:0] k, k_next;
  logic [NW-1:0] n, n_next;
  logic [31:0]   sum_before, sum_before_next;
  logic [31:0]   addend, addend_next;
  logic [31:0]   cmd_id, cmd_id_next;
  logic [31:0]   cmd_delay, cmd_delay_next;
  logic [31:0]   res_id, res_id_next;
  dltq_pkg::kind_t  res_kind, res_kind_next;
  dltq_pkg::entry_t carry, carry_next;

  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic [dltq_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
  dltq_pkg::entry_t        rd;

  logic            out_valid;
  dltq_pkg::kind_t out_kind;
  logic [31:0]     out_id;
  logic            out_last;
  logic            emit, emit_last;
  dltq_pkg::kind_t emit_kind;

  // Ring position of logical entry j, counted from the head.
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW + 1)'(DEPTH)) begin
      s = s - (AW + 1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  dltq_ram #(
    .WIDTH (dltq_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd = dltq_pkg::entry_t'(ram_rdata);

  // Conditions shared by the next-state and datapath logic.
  logic          cmd_fire, slot_free, more_k, ins_here, id_hit, pop_head, more_pop;
  logic [CW-1:0] k_inc;
  logic [NW-1:0] n_inc;
  logic [CW-1:0] count_dec;
  logic [32:0]   through;
  logic [31:0]   head_dec, new_delta;

  assign cmd.ready = (state == dltq_pkg::ST_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign slot_free = !out_valid || res.ready;
  assign k_inc     = CW'(k) + CW'(1);
  assign more_k    = k_inc < count;
  // The running sum through entry k is the time left of that entry.
  assign through   = {1'b0, sum_before} + {1'b0, rd.delta};
  // Only the head needs a strictly earlier deadline to be overtaken.
  assign ins_here  = (k == '0) ? (cmd_delay < rd.delta) : ({1'b0, cmd_delay} <= through);
  assign new_delta = cmd_delay - sum_before;
  assign id_hit    = (rd.id == cmd_id);
  assign head_dec  = (rd.delta != '0) ? rd.delta - 32'd1 : '0;
  assign pop_head  = (head_dec == '0);
  assign n_inc     = n + NW'(1);
  assign count_dec = count - CW'(1);
  assign more_pop  = (count_dec != '0) && (n_inc < NW'(dltq_pkg::MAX_RES));

  always_comb begin
    state_next = state;
    case (state)
      dltq_pkg::ST_IDLE: begin
        if (cmd_fire) begin
          case (dltq_pkg::func_t'(cmd.func))
            dltq_pkg::FUNC_INSERT: begin
              if (count == CW'(DEPTH) || count == '0) begin
                state_next = dltq_pkg::ST_RESP;
              end else begin
                state_next = dltq_pkg::ST_INS_SCAN;
              end
            end
            dltq_pkg::FUNC_CANCEL: begin
              if (count == '0) begin
                state_next = dltq_pkg::ST_RESP;
              end else begin
                state_next = dltq_pkg::ST_CAN_SCAN;
              end
            end
            dltq_pkg::FUNC_TICK: begin
              if (count != '0) begin
                state_next = dltq_pkg::ST_TICK_HEAD;
              end
            end
            default: state_next = dltq_pkg::ST_IDLE;
          endcase
        end
      end
      dltq_pkg::ST_INS_SCAN: begin
        if (ins_here) begin
          state_next = more_k ? dltq_pkg::ST_INS_SHIFT : dltq_pkg::ST_INS_TAIL;
        end else begin
          state_next = more_k ? dltq_pkg::ST_INS_SCAN : dltq_pkg::ST_RESP;
        end
      end
      dltq_pkg::ST_INS_SHIFT: begin
        state_next = more_k ? dltq_pkg::ST_INS_SHIFT : dltq_pkg::ST_INS_TAIL;
      end
      dltq_pkg::ST_INS_TAIL: state_next = dltq_pkg::ST_RESP;
      dltq_pkg::ST_CAN_SCAN: begin
        if (id_hit) begin
          state_next = more_k ? dltq_pkg::ST_CAN_SHIFT : dltq_pkg::ST_RESP;
        end else begin
          state_next = more_k ? dltq_pkg::ST_CAN_SCAN : dltq_pkg::ST_RESP;
        end
      end
      dltq_pkg::ST_CAN_SHIFT: begin
        state_next = more_k ? dltq_pkg::ST_CAN_SHIFT : dltq_pkg::ST_RESP;
      end
      dltq_pkg::ST_TICK_HEAD: begin
        if (!pop_head) begin
          state_next = dltq_pkg::ST_IDLE;
        end else begin
          state_next = more_pop ? dltq_pkg::ST_TICK_NEXT : dltq_pkg::ST_RESP;
        end
      end
      dltq_pkg::ST_TICK_NEXT: begin
        if (slot_free) begin
          if (rd.delta == '0) begin
            state_next = more_pop ? dltq_pkg::ST_TICK_NEXT : dltq_pkg::ST_RESP;
          end else begin
            state_next = dltq_pkg::ST_IDLE;
          end
        end
      end
      dltq_pkg::ST_RESP: begin
        if (slot_free) begin
          state_next = dltq_pkg::ST_IDLE;
        end
      end
      default: state_next = dltq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    count_next      = count;
    head_next       = head;
    k_next          = k;
    n_next          = n;
    sum_before_next = sum_before;
    addend_next     = addend;
    cmd_id_next     = cmd_id;
    cmd_delay_next  = cmd_delay;
    res_id_next     = res_id;
    res_kind_next   = res_kind;
    carry_next      = carry;
    ram_we          = 1'b0;
    ram_waddr       = head;
    ram_wdata       = carry;
    ram_re          = 1'b0;
    ram_raddr       = head;
    emit            = 1'b0;
    emit_kind       = res_kind;
    emit_last       = 1'b1;
    case (state)
      dltq_pkg::ST_IDLE: begin
        if (cmd_fire) begin
          cmd_id_next     = cmd.timer_id;
          cmd_delay_next  = cmd.delay_ticks;
          res_id_next     = cmd.timer_id;
          k_next          = '0;
          n_next          = '0;
          sum_before_next = '0;
          case (dltq_pkg::func_t'(cmd.func))
            dltq_pkg::FUNC_INSERT: begin
              if (count == CW'(DEPTH)) begin
                res_kind_next = dltq_pkg::KIND_REJECTED;
              end else begin
                res_kind_next = dltq_pkg::KIND_INSERTED;
                if (count == '0) begin
                  ram_we     = 1'b1;
                  ram_waddr  = head;
                  ram_wdata  = {cmd.timer_id, cmd.delay_ticks};
                  count_next = count + CW'(1);
                end else begin
                  ram_re = 1'b1;
                end
              end
            end
            dltq_pkg::FUNC_CANCEL: begin
              res_kind_next = dltq_pkg::KIND_NOT_FOUND;
              ram_re        = (count != '0);
            end
            dltq_pkg::FUNC_TICK: begin
              res_kind_next = dltq_pkg::KIND_EXPIRED;
              ram_re        = (count != '0);
            end
            default: ;
          endcase
        end
      end
      dltq_pkg::ST_INS_SCAN: begin
        if (ins_here) begin
          // New timer takes slot k; the old entry moves up with a smaller delta.
          ram_we     = 1'b1;
          ram_waddr  = wrap_add(head, k);
          ram_wdata  = {cmd_id, new_delta};
          carry_next = '{id: rd.id, delta: rd.delta - new_delta};
        end else begin
          sum_before_next = through[31:0];
        end
        if (more_k) begin
          ram_re    = 1'b1;
          ram_raddr = wrap_add(head, k_inc[AW-1:0]);
          k_next    = k_inc[AW-1:0];
        end else if (!ins_here) begin
          ram_we     = 1'b1;
          ram_waddr  = wrap_add(head, count[AW-1:0]);
          ram_wdata  = {cmd_id, cmd_delay - through[31:0]};
          count_next = count + CW'(1);
        end
      end
      dltq_pkg::ST_INS_SHIFT: begin
        ram_we     = 1'b1;
        ram_waddr  = wrap_add(head, k);
        ram_wdata  = carry;
        carry_next = rd;
        if (more_k) begin
          ram_re    = 1'b1;
          ram_raddr = wrap_add(head, k_inc[AW-1:0]);
          k_next    = k_inc[AW-1:0];
        end
      end
      dltq_pkg::ST_INS_TAIL: begin
        ram_we     = 1'b1;
        ram_waddr  = wrap_add(head, count[AW-1:0]);
        ram_wdata  = carry;
        count_next = count + CW'(1);
      end
      dltq_pkg::ST_CAN_SCAN: begin
        if (id_hit) begin
          res_kind_next = dltq_pkg::KIND_CANCELLED;
          addend_next   = rd.delta;
          if (!more_k) begin
            count_next = count_dec;
          end
        end
        if (more_k) begin
          ram_re    = 1'b1;
          ram_raddr = wrap_add(head, k_inc[AW-1:0]);
          k_next    = k_inc[AW-1:0];
        end
      end
      dltq_pkg::ST_CAN_SHIFT: begin
        // Entry k moves down one place; the first one absorbs the removed delta.
        ram_we      = 1'b1;
        ram_waddr   = wrap_add(head, k - AW'(1));
        ram_wdata   = {rd.id, rd.delta + addend};
        addend_next = '0;
        if (more_k) begin
          ram_re    = 1'b1;
          ram_raddr = wrap_add(head, k_inc[AW-1:0]);
          k_next    = k_inc[AW-1:0];
        end else begin
          count_next = count_dec;
        end
      end
      dltq_pkg::ST_TICK_HEAD: begin
        if (!pop_head) begin
          ram_we    = 1'b1;
          ram_waddr = head;
          ram_wdata = {rd.id, head_dec};
        end else begin
          res_id_next = rd.id;
          head_next   = wrap_add(head, AW'(1));
          count_next  = count_dec;
          n_next      = n_inc;
          if (more_pop) begin
            ram_re    = 1'b1;
            ram_raddr = wrap_add(head, AW'(1));
          end
        end
      end
      dltq_pkg::ST_TICK_NEXT: begin
        // The previous expiry is held until the new head shows whether it is last.
        if (slot_free) begin
          emit      = 1'b1;
          emit_kind = dltq_pkg::KIND_EXPIRED;
          if (rd.delta == '0) begin
            emit_last   = 1'b0;
            res_id_next = rd.id;
            head_next   = wrap_add(head, AW'(1));
            count_next  = count_dec;
            n_next      = n_inc;
            if (more_pop) begin
              ram_re    = 1'b1;
              ram_raddr = wrap_add(head, AW'(1));
            end
          end
        end
      end
      dltq_pkg::ST_RESP: begin
        emit = slot_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dltq_pkg::ST_IDLE;
      count     <= '0;
      head      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      head  <= head_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    k          <= k_next;
    n          <= n_next;
    sum_before <= sum_before_next;
    addend     <= addend_next;
    cmd_id     <= cmd_id_next;
    cmd_delay  <= cmd_delay_next;
    res_id     <= res_id_next;
    res_kind   <= res_kind_next;
    carry      <= carry_next;
    if (emit) begin
      out_kind <= emit_kind;
      out_id   <= res_id;
      out_last <= emit_last;
    end
  end

  assign res.valid        = out_valid;
  assign res.kind         = out_kind;
  assign res.timer_id_res = out_id;
  assign res.last         = out_last;

  `include "delta_list_timer_queue_assert.svh"

  // A new result word never overwrites one that the receiver has not taken.
  `DLTQ_ASSERT_NOW(a_no_overwrite, clk, rst, emit, slot_free)
  // The shifting walks never read and write the same entry in one cycle.
  `DLTQ_ASSERT_NOW(a_ram_no_clash, clk, rst, ram_we && ram_re, ram_waddr != ram_raddr)
  // A tick on an empty queue leaves the controller idle with nothing to send.
  `DLTQ_ASSERT_NEXT(a_empty_tick, clk, rst,
      cmd_fire && cmd.func == dltq_pkg::FUNC_TICK && count == '0,
      state == dltq_pkg::ST_IDLE && count == '0)

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;

  // The queue is built at its default depth, so a tick can never have more
  // entries to pop than the per-tick expiry limit.
  localparam int DEPTH           = dltq_pkg::DEPTH_DEFAULT;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int SETTLE_CYCLES   = 3 * DEPTH + 16;
  localparam int RANDOM_WORDS    = 70;

  // The fourth function code has no name in the package; the block ignores it.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // One result word as the checker expects to see it.
  typedef struct {
    dltq_pkg::kind_t kind;
    logic [31:0]     id;
    logic            last;
  } result_word_t;

  logic clk;
  logic rst;

  dltq_cmd_if cmd ();
  dltq_res_if res ();

  delta_list_timer_queue #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .res(res)
  );

  // Shadow copy of the timer list. Entry k holds its delay relative to entry
  // k-1, exactly as the block is meant to keep it.
  logic [31:0]  q_delta [DEPTH];
  logic [31:0]  q_id    [DEPTH];
  int           q_count = 0;

  // Result words still owed by the block, oldest first.
  result_word_t pending_results[$];

  int unsigned  err_count     = 0;
  int unsigned  idle_cycles   = 0;
  // When set, neither side inserts idle cycles.
  bit           steady_flow   = 1'b0;
  // A test sets this to ask the result side for one long hold-off.
  bit           sink_hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Idle lengths: mostly none or a few cycles, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------
  // Timer list predictor
  // ---------------------------------------------------------------------

  function automatic void q_remove(int pos);
    for (int j = pos; j + 1 < q_count; j++) begin
      q_delta[j] = q_delta[j + 1];
      q_id[j]    = q_id[j + 1];
    end
    q_count--;
  endfunction

  function automatic void q_place(int pos, logic [31:0] tid, logic [31:0] delta);
    for (int j = q_count; j > pos; j--) begin
      q_delta[j] = q_delta[j - 1];
      q_id[j]    = q_id[j - 1];
    end
    q_delta[pos] = delta;
    q_id[pos]    = tid;
    q_count++;
  endfunction

  // A new timer only overtakes the head when it is strictly earlier. Past the
  // head it goes in front of the first entry whose running sum reaches its
  // delay, or at the tail, and the entry it lands in front of gives up the
  // part of its delta that the new timer now covers.
  function automatic dltq_pkg::kind_t q_insert(logic [31:0] tid, logic [31:0] dly);
    longint unsigned sum_before;
    longint unsigned sum_through;
    logic [31:0]     new_delta;
    int              pos;
    if (q_count >= DEPTH) return dltq_pkg::KIND_REJECTED;
    new_delta = dly;
    pos       = 0;
    if (q_count > 0 && dly < q_delta[0]) begin
      q_delta[0] = q_delta[0] - dly;
    end else if (q_count > 0) begin
      sum_before = q_delta[0];
      pos        = q_count;
      for (int k = 1; k < q_count && pos == q_count; k++) begin
        sum_through = sum_before + q_delta[k];
        if (dly <= sum_through) begin
          new_delta  = 32'(dly - sum_before);
          q_delta[k] = q_delta[k] - new_delta;
          pos        = k;
        end else begin
          sum_before = sum_through;
        end
      end
      if (pos == q_count) new_delta = 32'(dly - sum_before);
    end
    q_place(pos, tid, new_delta);
    return dltq_pkg::KIND_INSERTED;
  endfunction

  // Only the first matching entry goes; its delta passes to its successor.
  function automatic dltq_pkg::kind_t q_cancel(logic [31:0] tid);
    for (int k = 0; k < q_count; k++) begin
      if (q_id[k] == tid) begin
        if (k + 1 < q_count) q_delta[k + 1] = q_delta[k + 1] + q_delta[k];
        q_remove(k);
        return dltq_pkg::KIND_CANCELLED;
      end
    end
    return dltq_pkg::KIND_NOT_FOUND;
  endfunction

  // Applies one accepted command word to the shadow list and queues the
  // result words it should produce.
  function automatic void timer_list_apply(logic [1:0] f, logic [31:0] tid,
                                           logic [31:0] dly);
    logic [31:0] popped;
    int          n;
    n = 0;
    case (f)
      dltq_pkg::FUNC_INSERT: begin
        pending_results.push_back('{q_insert(tid, dly), tid, 1'b1});
      end
      dltq_pkg::FUNC_CANCEL: begin
        pending_results.push_back('{q_cancel(tid), tid, 1'b1});
      end
      dltq_pkg::FUNC_TICK: begin
        // A head already at zero stays there and is popped.
        if (q_count > 0 && q_delta[0] != 0) q_delta[0] = q_delta[0] - 1;
        while (q_count > 0 && q_delta[0] == 0 && n < dltq_pkg::MAX_RES) begin
          popped = q_id[0];
          q_remove(0);
          n++;
          pending_results.push_back('{dltq_pkg::KIND_EXPIRED, popped,
              !(q_count > 0 && q_delta[0] == 0 && n < dltq_pkg::MAX_RES)});
        end
      end
      default: begin
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------

  // Offers one command word, waits for it to be taken, predicts its results
  // and then perhaps idles for a while.
  task automatic send_word(input logic [1:0] f, input logic [31:0] tid,
                           input logic [31:0] dly);
    int gap;
    cmd.valid       <= 1'b1;
    cmd.func        <= f;
    cmd.timer_id    <= tid;
    cmd.delay_ticks <= dly;
    do @(posedge clk); while (!cmd.ready);
    timer_list_apply(f, tid, dly);
    gap = steady_flow ? 0 : pick_gap();
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // The sender stops until the block has delivered everything it owes.
  task automatic wait_for_results();
    cmd.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // ---------------------------------------------------------------------
  // Result side: random back-pressure, plus one long hold-off on request
  // ---------------------------------------------------------------------

  initial begin : result_sink
    int run_len;
    int gap;
    res.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        res.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        res.ready <= 1'b1;
        run_len = $urandom_range(1, 24);
        repeat (run_len) @(posedge clk);
        gap = steady_flow ? 0 : pick_gap();
        if (gap > 0) begin
          res.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Every result word taken is matched against the oldest expectation. The
  // run carries on after a mismatch so that later faults are seen as well.
  always @(posedge clk) begin
    result_word_t want;
    if (!rst && res.valid && res.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: kind %0d, timer_id_res %0h, last %0b",
               res.kind, res.timer_id_res, res.last);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (res.kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, res.kind);
          err_count++;
        end
        if (res.timer_id_res !== want.id) begin
          $error("timer_id_res: expected %0h, actual %0h", want.id, res.timer_id_res);
          err_count++;
        end
        if (res.last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, res.last);
          err_count++;
        end
      end
    end
  end

  // The run is abandoned if neither channel moves a word for too long. The
  // longest legitimate quiet spell is the result hold-off.
  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL delta_list_timer_queue");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Hand-picked words: empty-queue behaviour, the unused code, extreme ids
  // and delays, tie ordering, duplicate ids and cancels at every position.
  task automatic test_directed_cases();
    send_word(dltq_pkg::FUNC_TICK, 32'h0000_0000, 32'h0000_0000);   // nothing to tick
    send_word(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);           // ignored outright
    send_word(dltq_pkg::FUNC_INSERT, 32'h0000_0000, 32'h0000_0000); // zero delay, empty
    send_word(dltq_pkg::FUNC_TICK, 32'h0000_0000, 32'h0000_0000);   // head already zero
    send_word(dltq_pkg::FUNC_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // longest delay
    send_word(dltq_pkg::FUNC_INSERT, 32'h0000_000A, 32'd5);         // strictly earlier
    send_word(dltq_pkg::FUNC_INSERT, 32'h0000_000B, 32'd5);         // ties with the head
    send_word(dltq_pkg::FUNC_INSERT, 32'h0000_000C, 32'd3);
    send_word(dltq_pkg::FUNC_INSERT, 32'h0000_000D, 32'd5);         // ties further down
    send_word(dltq_pkg::FUNC_INSERT, 32'h0000_000A, 32'd9);         // duplicate id
    send_word(dltq_pkg::FUNC_CANCEL, 32'h5555_AAAA, 32'h0000_0000); // id not present
    send_word(dltq_pkg::FUNC_CANCEL, 32'h0000_000B, 32'h0000_0000); // middle entry
    send_word(dltq_pkg::FUNC_CANCEL, 32'hFFFF_FFFF, 32'h0000_0000); // tail entry
    send_word(dltq_pkg::FUNC_CANCEL, 32'h0000_000C, 32'h0000_0000); // head entry
    send_word(dltq_pkg::FUNC_CANCEL, 32'h0000_000A, 32'h0000_0000); // first of two
    send_word(dltq_pkg::FUNC_INSERT, 32'h0000_0011, 32'd1);
    send_word(dltq_pkg::FUNC_INSERT, 32'h0000_0012, 32'd1);
    send_word(dltq_pkg::FUNC_TICK, 32'h0000_0000, 32'h0000_0000);   // two expire together
    repeat (4) send_word(dltq_pkg::FUNC_TICK, 32'h0000_0000, 32'h0000_0000);
    send_word(dltq_pkg::FUNC_CANCEL, 32'h0000_000A, 32'h0000_0000);
  endtask

  // Fills the queue while the result side is held off, so that the block
  // backs up and stalls its command input; then overfills it and lets every
  // timer run out on one tick.
  task automatic test_fill_under_stall();
    wait_for_results();
    while (q_count > 0) send_word(dltq_pkg::FUNC_CANCEL, q_id[q_count - 1], 32'h0000_0000);
    wait_for_results();
    sink_hold_req = 1'b1;
    for (int i = 0; i < DEPTH; i++) begin
      send_word(dltq_pkg::FUNC_INSERT, 32'hA000_0000 + i, 32'd2);
    end
    send_word(dltq_pkg::FUNC_INSERT, 32'hBEEF_0001, 32'd1);         // no room left
    send_word(dltq_pkg::FUNC_TICK, 32'h0000_0000, 32'h0000_0000);
    send_word(dltq_pkg::FUNC_TICK, 32'h0000_0000, 32'h0000_0000);   // every timer expires
    wait_for_results();
  endtask

  // Random traffic. Delays are mostly short so that timers really do expire,
  // and cancels mostly name a live timer. The first stretch runs without any
  // idling, and half way through the sender waits for the block to drain.
  task automatic test_random_traffic();
    int          counted;
    int          roll;
    bit          drained_once;
    logic [1:0]  f;
    logic [31:0] tid;
    logic [31:0] dly;
    counted      = 0;
    drained_once = 1'b0;
    steady_flow  = 1'b1;
    while (counted < RANDOM_WORDS) begin
      if (counted >= 20) steady_flow = 1'b0;
      if (counted >= 35 && !drained_once) begin
        drained_once = 1'b1;
        wait_for_results();
      end
      tid = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 7)) : 32'($urandom());
      case ($urandom_range(0, 19))
        0:       dly = 32'h0000_0000;
        1:       dly = 32'hFFFF_FFFF;
        2:       dly = $urandom();
        3:       dly = $urandom_range(0, 200);
        default: dly = $urandom_range(0, 6);
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 36) begin
        f = dltq_pkg::FUNC_INSERT;
      end else if (roll < 60) begin
        f = dltq_pkg::FUNC_CANCEL;
        if (q_count > 0 && $urandom_range(0, 9) < 8) tid = q_id[$urandom_range(0, q_count - 1)];
      end else if (roll < 96) begin
        f = dltq_pkg::FUNC_TICK;
      end else begin
        f = FUNC_UNUSED;
      end
      // Words the block merely ignores are not counted.
      if (f == dltq_pkg::FUNC_INSERT || f == dltq_pkg::FUNC_CANCEL ||
          (f == dltq_pkg::FUNC_TICK && q_count > 0)) counted++;
      send_word(f, tid, dly);
    end
    steady_flow = 1'b0;
  endtask

  // Reset with every input at a known value, run the tests in turn, wait for
  // the last result word and a settling spell, then give the verdict.
  initial begin : stimulus
    rst             = 1'b1;
    cmd.valid       = 1'b0;
    cmd.func        = dltq_pkg::FUNC_INSERT;
    cmd.timer_id    = '0;
    cmd.delay_ticks = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_fill_under_stall();
    test_random_traffic();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS delta_list_timer_queue");
    end else begin
      $display("FAIL delta_list_timer_queue");
    end
    $finish;
  end

endmodule
